// ----- hdl/fifo_icache_fetch_decode_macros.svh -----
// Assertion macros for the instruction fetch front end.
// Included by the top level; expects a signal named clock and one named reset.
`ifndef FIFO_ICACHE_FETCH_DECODE_MACROS_SVH
`define FIFO_ICACHE_FETCH_DECODE_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- hdl/fifd_pkg.sv -----
// Shared constants and types for the instruction fetch front end.
// No dependencies.
`default_nettype none
package fifd_pkg;

   localparam int CACHE_ENTRIES = 16;
   localparam int SLOT_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_FILL   = 1'b1;

   typedef struct packed {
      logic        active;
      logic        found;
      logic [31:0] addr;
      logic [31:0] word;
   } probe_type;

endpackage
`default_nettype wire

// ----- hdl/fifd_cell.sv -----
// One cache entry of the lookup chain: holds tag, word and valid bit,
// compares the passing probe and hands it to the next cell. Uses fifd_pkg.
`default_nettype none
module fifd_cell
   import fifd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire probe_type   probe_in,
   output probe_type        probe_out,
   input  wire logic        wr_en,
   input  wire logic [31:0] wr_addr,
   input  wire logic [31:0] wr_word
);

   logic [31:0] tag_ff;
   logic [31:0] word_ff;
   logic        valid_ff;
   probe_type   probe_ff;
   probe_type   probe_in_n;
   logic        match;

   assign match = probe_in.active && !probe_in.found && valid_ff && (tag_ff == probe_in.addr);

   always_comb begin
      probe_in_n = probe_in;
      if (match) begin
         probe_in_n.found = 1'b1;
         probe_in_n.word  = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         probe_ff.active <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff <= 1'b1;
         end
         probe_ff.active <= probe_in_n.active;
      end
      probe_ff.found <= probe_in_n.found;
      probe_ff.addr  <= probe_in_n.addr;
      probe_ff.word  <= probe_in_n.word;
      if (wr_en) begin
         tag_ff  <= wr_addr;
         word_ff <= wr_word;
      end
   end

   assign probe_out = probe_ff;

endmodule
`default_nettype wire

// ----- hdl/fifd_decode.sv -----
// Result formatting: byte swap of the instruction word and field split.
// Uses fifd_pkg.
`default_nettype none
module fifd_decode
   import fifd_pkg::*;
(
   input  wire logic        hit,
   input  wire logic [31:0] raw,
   output logic [31:0]      instruction,
   output logic [5:0]       major_op,
   output logic             imm_flag,
   output logic             branch_mode,
   output logic [3:0]       reg_a,
   output logic [3:0]       reg_b,
   output logic [3:0]       reg_c,
   output logic [15:0]      immediate
);

   logic [31:0] ir;

   assign ir          = hit ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : 32'd0;
   assign instruction = ir;
   assign major_op    = ir[31:26];
   assign imm_flag    = ir[25];
   assign branch_mode = ir[24];
   assign reg_a       = ir[23:20];
   assign reg_b       = ir[19:16];
   assign reg_c       = ir[15:12];
   assign immediate   = {ir[7:0], ir[15:8]};

endmodule
`default_nettype wire

// ----- hdl/fifo_icache_fetch_decode.sv -----
// Top level of the instruction fetch front end: chain of cache cells,
// fill pointer and result decode. Uses fifd_pkg, fifd_cell, fifd_decode.
//
// Usage: raise start with req_opcode, req_fetch_address, req_memory_word;
// the word is taken at a clock edge where start is high and busy is low.
// Every word gives exactly one result, shown for one cycle with rsp_valid.
// Fill (opcode 1): writes the slot named by the round-robin pointer, result
// the cycle after acceptance; busy stays low, so fills run one per cycle
// unless a lookup holds busy. Lookup (opcode 0): the probe walks the chain
// of CACHE_ENTRIES cells, one cell per cycle, the first valid matching cell
// capturing its word. The result appears when the probe leaves the last
// cell; busy is high during that walk, so a new word is taken the cycle
// after the result.
// A miss reports rsp_hit low and all other fields zero.
// Reset (synchronous, active high) clears all valid bits, the pointer and
// the chain at once; no clearing pass. The receiver cannot stall results.
`default_nettype none
`include "fifo_icache_fetch_decode_macros.svh"
module fifo_icache_fetch_decode
   import fifd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_opcode,
   input  wire logic [31:0] req_fetch_address,
   input  wire logic [31:0] req_memory_word,
   output logic             rsp_valid,
   output logic             rsp_hit,
   output logic [31:0]      rsp_instruction,
   output logic [5:0]       rsp_major_op,
   output logic             rsp_imm_flag,
   output logic             rsp_branch_mode,
   output logic [3:0]       rsp_reg_a,
   output logic [3:0]       rsp_reg_b,
   output logic [3:0]       rsp_reg_c,
   output logic [15:0]      rsp_immediate
);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CACHE_ENTRIES - 1);

   logic              busy_ff, busy_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              fill_done_ff;
   logic [31:0]       fill_word_ff;
   logic              accept, fill_accept, lookup_accept;
   probe_type         chain [0:CACHE_ENTRIES];
   probe_type         tail;
   logic [31:0]       raw;

   assign busy          = busy_ff;
   assign accept        = start && !busy_ff;
   assign fill_accept   = accept && (req_opcode == OP_FILL);
   assign lookup_accept = accept && (req_opcode == OP_LOOKUP);

   assign chain[0] = '{active: lookup_accept, found: 1'b0,
                       addr: req_fetch_address, word: 32'd0};

   for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
      fifd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .probe_in  (chain[i]),
         .probe_out (chain[i+1]),
         .wr_en     (fill_accept && (slot_ff == SLOT_W'(i))),
         .wr_addr   (req_fetch_address),
         .wr_word   (req_memory_word)
      );
   end

   assign tail = chain[CACHE_ENTRIES];

   always_comb begin
      busy_in = busy_ff;
      if (lookup_accept) begin
         busy_in = 1'b1;
      end else if (tail.active) begin
         busy_in = 1'b0;
      end
      slot_in = slot_ff;
      if (fill_accept) begin
         slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         slot_ff      <= '0;
         fill_done_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         slot_ff      <= slot_in;
         fill_done_ff <= fill_accept;
      end
      if (fill_accept) begin
         fill_word_ff <= req_memory_word;
      end
   end

   assign rsp_valid = fill_done_ff || tail.active;
   assign rsp_hit   = fill_done_ff || (tail.active && tail.found);
   assign raw       = fill_done_ff ? fill_word_ff : tail.word;

   fifd_decode u_decode (
      .hit         (rsp_hit),
      .raw         (raw),
      .instruction (rsp_instruction),
      .major_op    (rsp_major_op),
      .imm_flag    (rsp_imm_flag),
      .branch_mode (rsp_branch_mode),
      .reg_a       (rsp_reg_a),
      .reg_b       (rsp_reg_b),
      .reg_c       (rsp_reg_c),
      .immediate   (rsp_immediate)
   );

   `ASSERT_IMPL(a_one_source, fill_done_ff, !tail.active, "fill and lookup results collide")
   `ASSERT_NEXT(a_lookup_busy, lookup_accept, busy, "busy low after lookup accepted")
   `ASSERT_NEXT(a_fill_result, fill_accept, rsp_valid && rsp_hit, "fill result missing")
   `ASSERT_IMPL(a_miss_zero, rsp_valid && !rsp_hit, rsp_instruction == 32'd0,
                "miss with nonzero instruction")

endmodule
`default_nettype wire

// ----- dv/fifd_checker.sv -----
// Checker for the instruction fetch front end: keeps its own copy of the cache,
// predicts one result per accepted word and compares it with each result strobe.
// Depends on fifd_pkg.
`default_nettype none
module fifd_checker
   import fifd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic        req_opcode,
   input  wire logic [31:0] req_fetch_address,
   input  wire logic [31:0] req_memory_word,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_hit,
   input  wire logic [31:0] rsp_instruction,
   input  wire logic [5:0]  rsp_major_op,
   input  wire logic        rsp_imm_flag,
   input  wire logic        rsp_branch_mode,
   input  wire logic [3:0]  rsp_reg_a,
   input  wire logic [3:0]  rsp_reg_b,
   input  wire logic [3:0]  rsp_reg_c,
   input  wire logic [15:0] rsp_immediate,
   output int               fail_count,
   output int               words_pending
);

   typedef struct packed {
      logic        hit;
      logic [31:0] instruction;
      logic [5:0]  major_op;
      logic        imm_flag;
      logic        branch_mode;
      logic [3:0]  reg_a;
      logic [3:0]  reg_b;
      logic [3:0]  reg_c;
      logic [15:0] immediate;
   } fetch_result_type;

   logic [31:0]              mirror_tag  [CACHE_ENTRIES];
   logic [31:0]              mirror_word [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] mirror_valid;
   logic [SLOT_W-1:0]        fill_slot;
   fetch_result_type         results_due [$];
   int                       errors = 0;

   initial begin
      fail_count    = 0;
      words_pending = 0;
   end

   function automatic fetch_result_type decode_fetch(input logic hit,
                                                     input logic [31:0] raw);
      fetch_result_type r;
      logic [31:0]      ir;
      ir            = hit ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : 32'h0;
      r.hit         = hit;
      r.instruction = ir;
      r.major_op    = ir[31:26];
      r.imm_flag    = ir[25];
      r.branch_mode = ir[24];
      r.reg_a       = ir[23:20];
      r.reg_b       = ir[19:16];
      r.reg_c       = ir[15:12];
      r.immediate   = {ir[7:0], ir[15:8]};
      return r;
   endfunction

   // lowest valid match wins
   function automatic fetch_result_type lookup_fetch(input logic [31:0] addr);
      for (int i = 0; i < CACHE_ENTRIES; i++)
         if (mirror_valid[i] && mirror_tag[i] == addr)
            return decode_fetch(1'b1, mirror_word[i]);
      return decode_fetch(1'b0, 32'h0);
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      fetch_result_type want;
      if (reset) begin
         mirror_valid = '0;
         fill_slot    = '0;
         results_due.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (results_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual instruction %h",
                        $time, rsp_instruction);
               errors++;
            end else begin
               want = results_due.pop_front();
               check_field("hit", 32'(want.hit), 32'(rsp_hit));
               check_field("instruction", want.instruction, rsp_instruction);
               check_field("major_op", 32'(want.major_op), 32'(rsp_major_op));
               check_field("imm_flag", 32'(want.imm_flag), 32'(rsp_imm_flag));
               check_field("branch_mode", 32'(want.branch_mode), 32'(rsp_branch_mode));
               check_field("reg_a", 32'(want.reg_a), 32'(rsp_reg_a));
               check_field("reg_b", 32'(want.reg_b), 32'(rsp_reg_b));
               check_field("reg_c", 32'(want.reg_c), 32'(rsp_reg_c));
               check_field("immediate", 32'(want.immediate), 32'(rsp_immediate));
            end
         end
         if (start && !busy) begin
            if (req_opcode == OP_FILL) begin
               mirror_tag[fill_slot]  = req_fetch_address;
               mirror_word[fill_slot] = req_memory_word;
               mirror_valid[fill_slot] = 1'b1;
               if (fill_slot == SLOT_W'(CACHE_ENTRIES - 1))
                  fill_slot = '0;
               else
                  fill_slot = fill_slot + 1'b1;
               results_due.push_back(decode_fetch(1'b1, req_memory_word));
            end else begin
               results_due.push_back(lookup_fetch(req_fetch_address));
            end
         end
      end
      fail_count    <= errors;
      words_pending <= results_due.size();
   end

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Testbench top for the instruction fetch front end: clock, reset and fetch/fill
// stimulus with bursty idling, final verdict. Depends on fifd_pkg, fifd_checker
// and fifo_icache_fetch_decode.
`default_nettype none
module tb_top
   import fifd_pkg::*;
();

   localparam int   RANDOM_WORDS = 1550;
   localparam int   CYCLE_LIMIT  = 400000;
   localparam int   DRAIN_CYCLES = CACHE_ENTRIES + 8;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_opcode;
   logic [31:0] req_fetch_address;
   logic [31:0] req_memory_word;
   logic        rsp_valid;
   logic        rsp_hit;
   logic [31:0] rsp_instruction;
   logic [5:0]  rsp_major_op;
   logic        rsp_imm_flag;
   logic        rsp_branch_mode;
   logic [3:0]  rsp_reg_a;
   logic [3:0]  rsp_reg_b;
   logic [3:0]  rsp_reg_c;
   logic [15:0] rsp_immediate;
   int          fail_count;
   int          words_pending;
   int          cycle_count = 0;
   logic [31:0] filled_addrs [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fifo_icache_fetch_decode DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_fetch_address(req_fetch_address),
      .req_memory_word(req_memory_word), .rsp_valid(rsp_valid), .rsp_hit(rsp_hit),
      .rsp_instruction(rsp_instruction), .rsp_major_op(rsp_major_op),
      .rsp_imm_flag(rsp_imm_flag), .rsp_branch_mode(rsp_branch_mode),
      .rsp_reg_a(rsp_reg_a), .rsp_reg_b(rsp_reg_b), .rsp_reg_c(rsp_reg_c),
      .rsp_immediate(rsp_immediate)
   );

   fifd_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_fetch_address(req_fetch_address),
      .req_memory_word(req_memory_word), .rsp_valid(rsp_valid), .rsp_hit(rsp_hit),
      .rsp_instruction(rsp_instruction), .rsp_major_op(rsp_major_op),
      .rsp_imm_flag(rsp_imm_flag), .rsp_branch_mode(rsp_branch_mode),
      .rsp_reg_a(rsp_reg_a), .rsp_reg_b(rsp_reg_b), .rsp_reg_c(rsp_reg_c),
      .rsp_immediate(rsp_immediate), .fail_count(fail_count),
      .words_pending(words_pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // returns at the edge that takes the word
   task automatic send_word(input logic op, input logic [31:0] addr, input logic [31:0] mem);
      req_opcode        <= op;
      req_fetch_address <= addr;
      req_memory_word   <= mem;
      start             <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (op == OP_FILL) begin
         filled_addrs.push_back(addr);
         if (filled_addrs.size() > 48) void'(filled_addrs.pop_front());
      end
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // recent fills: most still cached, some already evicted
   function automatic logic [31:0] pick_recent();
      int span;
      span = (filled_addrs.size() < 24) ? filled_addrs.size() : 24;
      return filled_addrs[filled_addrs.size() - 1 - $urandom_range(0, span - 1)];
   endfunction

   initial begin
      int          roll;
      int          burst_left;
      logic        op;
      logic [31:0] addr;
      logic [31:0] mem;

      reset             <= 1'b1;
      start             <= 1'b0;
      req_opcode        <= OP_LOOKUP;
      req_fetch_address <= '0;
      req_memory_word   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty cache, extremes, duplicate fill, near miss
      send_word(OP_LOOKUP, 32'h0000_0000, 32'hffff_ffff);
      send_word(OP_LOOKUP, 32'hffff_ffff, 32'h0000_0000);
      send_word(OP_FILL,   32'h0000_0000, 32'h0000_0000);
      send_word(OP_FILL,   32'hffff_ffff, 32'hffff_ffff);
      send_word(OP_FILL,   32'h0000_1000, 32'h1234_5678);
      send_word(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send_word(OP_LOOKUP, 32'hffff_ffff, 32'h0000_0000);
      send_word(OP_LOOKUP, 32'h0000_1000, 32'h0000_0000);
      send_word(OP_FILL,   32'h0000_1000, 32'h89ab_cdef);
      send_word(OP_LOOKUP, 32'h0000_1000, 32'h0000_0000);
      send_word(OP_FILL,   32'h8000_0004, 32'ha5a5_5a5a);
      send_word(OP_LOOKUP, 32'h8000_0004, 32'h0000_0000);
      send_word(OP_LOOKUP, 32'h0000_1001, 32'h0000_0000);
      send_word(OP_FILL,   32'h7fff_fffc, 32'h5a5a_a5a5);
      send_word(OP_LOOKUP, 32'h7fff_fffc, 32'hffff_ffff);
      idle_cycles(3);

      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         roll = $urandom_range(0, 99);
         mem  = $urandom;
         if (roll < 40) begin
            op   = OP_FILL;
            addr = (roll < 12) ? pick_recent() : $urandom;
            if (roll == 0) mem = '0;
            if (roll == 1) mem = '1;
         end else if (roll < 85) begin
            op   = OP_LOOKUP;
            addr = pick_recent();
         end else if (roll < 93) begin
            op   = OP_LOOKUP;
            addr = pick_recent() ^ (32'h1 << $urandom_range(0, 31));
         end else begin
            op   = OP_LOOKUP;
            addr = $urandom;
         end
         send_word(op, addr, mem);
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            // every third stretch of 250 words runs without gaps
            if ((n / 250) % 3 != 1 && $urandom_range(0, 4) != 0)
               idle_cycles($urandom_range(1, 2 * CACHE_ENTRIES));
         end
      end
      start <= 1'b0;

      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire
